/* rtl/core/uri_pct_pkg.sv */
// uri_pct_pkg: shared types, codes and character helpers for the URI percent codec.
// No dependencies; used by uri_pct_step and uri_percent_codec.

package uri_pct_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ESC_SLASH = 1'b1;

	// Direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Decoder phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] PH_DROP = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_TRUNC  = 2'd1;
	localparam logic [1:0] ST_NONHEX = 2'd2;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	typedef struct packed {
		logic direction;
		logic esc_slash;
	} cfg_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] nibble;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// Unreserved, generic reserved marks, and '/' unless it is to be escaped
	function automatic logic passes_plain(input logic [7:0] c, input logic esc_slash);
		logic r;
		r = 1'b0;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
		    (c >= 8'h30 && c <= 8'h39))
			r = 1'b1;
		case (c)
			8'h2D, 8'h2E, 8'h5F, 8'h7E,
			8'h3A, 8'h40, 8'h21, 8'h24, 8'h26, 8'h27,
			8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
			CH_SLASH: r = !esc_slash;
			default: ;
		endcase
		return r;
	endfunction

	// Hex digit of either case to its value
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t h;
		logic [7:0] t;
		h = '0;
		t = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			h.valid = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			h.valid = 1'b1;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			h.valid = 1'b1;
		end
		h.value = t[3:0];
		return h;
	endfunction

	// Upper-case hex character for a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		case (n)
			4'h0: r = 8'h30;
			4'h1: r = 8'h31;
			4'h2: r = 8'h32;
			4'h3: r = 8'h33;
			4'h4: r = 8'h34;
			4'h5: r = 8'h35;
			4'h6: r = 8'h36;
			4'h7: r = 8'h37;
			4'h8: r = 8'h38;
			4'h9: r = 8'h39;
			4'hA: r = 8'h41;
			4'hB: r = 8'h42;
			4'hC: r = 8'h43;
			4'hD: r = 8'h44;
			4'hE: r = 8'h45;
			default: r = 8'h46;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/uri_percent_codec.sv */
// uri_percent_codec: top level of the byte-stream URI percent encoder/decoder.
// Depends on uri_pct_pkg and uri_pct_step.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): one byte plus a string_last flag per transfer.
//  - out channel (out_valid/out_ready/out_data): one result per transfer: byte, status,
//    run_last (last result of its input byte) and string_end (last result of a string).
//  - cfg port: cfg_we with cfg_index/cfg_wdata writes direction (0 encode, 1 decode) or
//    the slash-escape flag. Write only while the codec is idle; a direction write clears
//    the decoder. No read-back.
//  - A taken byte waits in the input register; its results reach out via the result register.
//  - Throughput: one input byte per cycle when each gives at most one result and out does
//    not stall. A byte that encodes to an escape holds the input register until all three
//    result bytes are out, since the single result register takes one result per cycle.
//    Bytes that give no result (escape digits being gathered, dropped tail) retire at once.
//  - Stall: while out_ready is low the result register holds; a byte still owing
//    results stays in the input register and in_ready drops. A byte giving no result
//    still retires.
//  - Reset (arst_n low): both registers empty, encode direction, slash passes, decoder idle.

module uri_percent_codec (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  uri_pct_pkg::in_item_t                in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output uri_pct_pkg::out_item_t               out_data,
	input  logic                                 cfg_we,
	input  logic [uri_pct_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic                                 cfg_wdata
);

	// Input register
	logic                   valid_s1;
	uri_pct_pkg::in_item_t  item_s1;
	logic [1:0]             idx_q;      // which result of the held byte is next

	// Configuration and decoder state
	uri_pct_pkg::cfg_t       cfg_q;
	uri_pct_pkg::dec_state_t state_q;

	// Result register
	logic                   out_valid_q;
	uri_pct_pkg::out_item_t out_data_q;

	uri_pct_pkg::out_item_t  res;
	logic [1:0]              res_count;
	uri_pct_pkg::dec_state_t next_state;

	logic out_free;   // result register can take a result this cycle
	logic emit;       // a result moves into the result register
	logic s1_done;    // held byte retires this cycle

	uri_pct_step u_step (
		.item       (item_s1),
		.cfg        (cfg_q),
		.state      (state_q),
		.idx        (idx_q),
		.res        (res),
		.res_count  (res_count),
		.next_state (next_state)
	);

	assign out_free = !out_valid_q || out_ready;
	assign emit     = valid_s1 && (res_count != 2'd0) && out_free;
	// retire after the final result, or at once when the byte gives none
	assign s1_done  = valid_s1 && ((res_count == 2'd0) ||
	                               (out_free && (idx_q == res_count - 2'd1)));
	assign in_ready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s1_done)
				idx_q <= 2'd0;
			else if (emit)
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
	end

	// Config and decoder state; a direction write resets the decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= '{direction: uri_pct_pkg::DIR_ENCODE, esc_slash: 1'b0};
			state_q <= '{phase: uri_pct_pkg::PH_IDLE, nibble: 4'h0};
		end else begin
			if (cfg_we && cfg_index == uri_pct_pkg::REG_DIRECTION) begin
				cfg_q.direction <= cfg_wdata;
				state_q         <= '{phase: uri_pct_pkg::PH_IDLE, nibble: 4'h0};
			end else if (s1_done) begin
				state_q <= next_state;
			end
			if (cfg_we && cfg_index == uri_pct_pkg::REG_ESC_SLASH)
				cfg_q.esc_slash <= cfg_wdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	// a partly emitted escape always has its byte still held
	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> valid_s1)
		else $error("result index set with no held byte");

	// only encoding yields more than one result per byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> (cfg_q.direction == uri_pct_pkg::DIR_ENCODE))
		else $error("multi-result byte while decoding");

	// the decoder leaves idle only in decode direction
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase != uri_pct_pkg::PH_IDLE) |->
		(cfg_q.direction == uri_pct_pkg::DIR_DECODE))
		else $error("decoder busy in encode direction");

	// an error result carries a zero byte and closes both the byte and the string
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status != uri_pct_pkg::ST_OK) |->
		(out_data_q.out_byte == 8'h00 && out_data_q.run_last && out_data_q.string_end))
		else $error("malformed error result");

	// the result index holds while the result register is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (idx_q == $past(idx_q)))
		else $error("result index moved during output stall");
`endif

endmodule

/* rtl/core/uri_pct_step.sv */
// uri_pct_step: combinational encode/decode step for one held input byte.
// Depends on uri_pct_pkg. Gives the result at slot idx, result count, next decoder state.

module uri_pct_step (
	input  uri_pct_pkg::in_item_t   item,
	input  uri_pct_pkg::cfg_t       cfg,
	input  uri_pct_pkg::dec_state_t state,
	input  logic [1:0]              idx,
	output uri_pct_pkg::out_item_t  res,
	output logic [1:0]              res_count,
	output uri_pct_pkg::dec_state_t next_state
);

	uri_pct_pkg::hex_digit_t dig;
	logic                    last;
	logic [7:0]              c;

	assign c    = item.data_byte;
	assign last = item.string_last;
	assign dig  = uri_pct_pkg::hex_decode(c);

	always_comb begin
		res        = '0;
		res_count  = 2'd0;
		next_state = state;
		if (cfg.direction == uri_pct_pkg::DIR_ENCODE) begin
			if (uri_pct_pkg::passes_plain(c, cfg.esc_slash)) begin
				res_count = 2'd1;
				res       = '{out_byte: c, status: uri_pct_pkg::ST_OK,
				              run_last: 1'b1, string_end: last};
			end else begin
				res_count = 2'd3;
				case (idx)
					2'd0: res.out_byte = uri_pct_pkg::CH_PERCENT;
					2'd1: res.out_byte = uri_pct_pkg::hex_char(c[7:4]);
					default: begin
						res.out_byte   = uri_pct_pkg::hex_char(c[3:0]);
						res.run_last   = 1'b1;
						res.string_end = last;
					end
				endcase
			end
		end else begin
			case (state.phase)
				uri_pct_pkg::PH_IDLE: begin
					if (c != uri_pct_pkg::CH_PERCENT) begin
						res_count = 2'd1;
						res       = '{out_byte: c, status: uri_pct_pkg::ST_OK,
						              run_last: 1'b1, string_end: last};
					end else if (last) begin
						res_count  = 2'd1;
						res        = '{out_byte: 8'h00, status: uri_pct_pkg::ST_TRUNC,
						               run_last: 1'b1, string_end: 1'b1};
						next_state = '{phase: uri_pct_pkg::PH_IDLE, nibble: 4'h0};
					end else begin
						next_state.phase = uri_pct_pkg::PH_HIGH;
					end
				end
				uri_pct_pkg::PH_HIGH: begin
					// truncation is checked before the digit itself
					if (last || !dig.valid) begin
						res_count  = 2'd1;
						res        = '{out_byte: 8'h00,
						               status: last ? uri_pct_pkg::ST_TRUNC
						                            : uri_pct_pkg::ST_NONHEX,
						               run_last: 1'b1, string_end: 1'b1};
						next_state = '{phase: last ? uri_pct_pkg::PH_IDLE
						                           : uri_pct_pkg::PH_DROP,
						               nibble: 4'h0};
					end else begin
						next_state = '{phase: uri_pct_pkg::PH_LOW, nibble: dig.value};
					end
				end
				uri_pct_pkg::PH_LOW: begin
					res_count = 2'd1;
					if (!dig.valid) begin
						res        = '{out_byte: 8'h00, status: uri_pct_pkg::ST_NONHEX,
						               run_last: 1'b1, string_end: 1'b1};
						next_state = '{phase: last ? uri_pct_pkg::PH_IDLE
						                           : uri_pct_pkg::PH_DROP,
						               nibble: 4'h0};
					end else begin
						res        = '{out_byte: {state.nibble, dig.value},
						               status: uri_pct_pkg::ST_OK,
						               run_last: 1'b1, string_end: last};
						next_state = '{phase: uri_pct_pkg::PH_IDLE, nibble: 4'h0};
					end
				end
				default: begin
					// dropping the tail of a failed string
					if (last)
						next_state.phase = uri_pct_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb_uri_percent_codec.sv */
// tb_uri_percent_codec: self-checking testbench for the URI percent encoder/decoder.
// Depends on uri_pct_pkg and the uri_percent_codec RTL; needs nothing else to run.
// Directed escapes and error cases first, then random strings under random flow control.
`timescale 1ns / 1ps

import uri_pct_pkg::*;

module tb_uri_percent_codec;

	// Expected-result store with its own copy of the codec's registers and decoder state.
	// Every accepted input transfer is turned into the results it should cause.
	// Every output transfer is checked against the oldest of them.
	class codec_scoreboard;
		out_item_t  pending_q[$];
		int         fail_count;
		logic       dir;
		logic       slash;
		logic [1:0] phase;
		logic [3:0] nibble;

		function new();
			fail_count = 0;
			dir = DIR_ENCODE;
			slash = 1'b0;
			phase = PH_IDLE;
			nibble = 4'h0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// Letters, digits, - . _ ~ and the generic marks : @ ! $ & ' ( ) * + , ; =
		function bit is_plain(logic [7:0] c);
			if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
				return 1'b1;
			case (c)
				"-", ".", "_", "~", ":", "@", "!", "$", "&", 8'h27,
				"(", ")", "*", "+", ",", ";", "=": return 1'b1;
				CH_SLASH: return !slash;
				default: return 1'b0;
			endcase
		endfunction

		// Bit 4 set means not a hex digit
		function logic [4:0] digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return {1'b0, 4'(c - "0")};
			if (c >= "a" && c <= "f")
				return {1'b0, 4'(c - "a" + 8'd10)};
			if (c >= "A" && c <= "F")
				return {1'b0, 4'(c - "A" + 8'd10)};
			return 5'h10;
		endfunction

		function logic [7:0] hex_upper(logic [3:0] n);
			if (n < 4'd10)
				return 8'("0") + 8'(n);
			return 8'("A") + 8'(n) - 8'd10;
		endfunction

		function void queue_result(logic [7:0] b, logic [1:0] st, logic rl, logic se);
			out_item_t r;
			r.out_byte = b;
			r.status = st;
			r.run_last = rl;
			r.string_end = se;
			pending_q.insert(pending_q.size(), r);
		endfunction

		// Bad escape: one error result, then drop the rest unless the string ends here
		function void raise_error(logic [1:0] st, logic lst);
			queue_result(8'h00, st, 1'b1, 1'b1);
			phase = lst ? PH_IDLE : PH_DROP;
			nibble = 4'h0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic val);
			if (idx == REG_DIRECTION) begin
				dir = val;
				phase = PH_IDLE;
				nibble = 4'h0;
			end else if (idx == REG_ESC_SLASH) begin
				slash = val;
			end
		endfunction

		// Returns 0 when the byte is simply swallowed as part of a dropped tail
		function bit note_input(in_item_t it);
			logic [7:0] c;
			logic       lst;
			logic [4:0] d;
			bit         used;
			c = it.data_byte;
			lst = it.string_last;
			used = 1'b1;
			if (dir == DIR_ENCODE) begin
				if (is_plain(c)) begin
					queue_result(c, ST_OK, 1'b1, lst);
				end else begin
					queue_result(CH_PERCENT, ST_OK, 1'b0, 1'b0);
					queue_result(hex_upper(c[7:4]), ST_OK, 1'b0, 1'b0);
					queue_result(hex_upper(c[3:0]), ST_OK, 1'b1, lst);
				end
				return used;
			end
			d = digit_value(c);
			case (phase)
				PH_IDLE: begin
					if (c != CH_PERCENT)
						queue_result(c, ST_OK, 1'b1, lst);
					else if (lst)
						raise_error(ST_TRUNC, lst);
					else
						phase = PH_HIGH;
				end
				PH_HIGH: begin
					// truncation wins over a bad digit
					if (lst)
						raise_error(ST_TRUNC, lst);
					else if (d[4])
						raise_error(ST_NONHEX, lst);
					else begin
						nibble = d[3:0];
						phase = PH_LOW;
					end
				end
				PH_LOW: begin
					if (d[4])
						raise_error(ST_NONHEX, lst);
					else begin
						queue_result({nibble, d[3:0]}, ST_OK, 1'b1, lst);
						phase = PH_IDLE;
						nibble = 4'h0;
					end
				end
				default: begin
					used = 1'b0;
					if (lst)
						phase = PH_IDLE;
				end
			endcase
			return used;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, actual byte=%02h status=%0d",
					$time, got.out_byte, got.status);
				$display("%0t:   run_last=%0b string_end=%0b",
					$time, got.run_last, got.string_end);
				fail_count++;
				return;
			end
			want = pending_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, got.out_byte);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				fail_count++;
			end
			if (got.run_last !== want.run_last) begin
				$display("%0t: run_last expected %0b actual %0b", $time, want.run_last, got.run_last);
				fail_count++;
			end
			if (got.string_end !== want.string_end) begin
				$display("%0t: string_end expected %0b actual %0b", $time, want.string_end,
					got.string_end);
				fail_count++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic                   cfg_wdata;

	codec_scoreboard sb = new();

	// Sender pacing and receiver hold-off request
	int burst_left = 0;
	int counted = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	uri_percent_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Values read just after the edge are the ones the DUT saw at that edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Offer one byte; bursts of random length, random gaps in between.
	// Returns at the edge where the transfer happened.
	task automatic offer(input logic [7:0] b, input logic lst);
		in_item_t item;
		item.data_byte = b;
		item.string_last = lst;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (sb.note_input(item))
			counted++;
	endtask

	// Stop sending until every expected result is out, plus a few cycles for a
	// byte that gives no result to retire.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One write cycle, then cfg_we drops before the next write so back-to-back writes never collide
	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex_char();
		logic [3:0] v;
		v = 4'($urandom_range(0, 15));
		if (v < 4'd10)
			return 8'("0") + 8'(v);
		return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
	endfunction

	// Decoder string: mostly plain bytes and good escapes, some broken escapes and noise.
	// Occasionally an early string_last splits it.
	task automatic send_decode_string();
		logic [7:0] bytes_q[$];
		logic [7:0] b;
		int         n_tok;
		int         kind;
		n_tok = $urandom_range(1, 6);
		repeat (n_tok) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				b = 8'($urandom_range(0, 255));
				bytes_q.insert(bytes_q.size(), b == CH_PERCENT ? 8'("x") : b);
			end else if (kind < 8) begin
				bytes_q.insert(bytes_q.size(), CH_PERCENT);
				bytes_q.insert(bytes_q.size(), rand_hex_char());
				bytes_q.insert(bytes_q.size(), rand_hex_char());
			end else if (kind == 8) begin
				bytes_q.insert(bytes_q.size(), CH_PERCENT);
				bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
				bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
			end else begin
				bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
			end
		end
		foreach (bytes_q[i])
			offer(bytes_q[i], (i == bytes_q.size() - 1) || ($urandom_range(0, 29) == 0));
	endtask

	// Receiver: segments of always-ready, coin-flip and two fixed duty patterns,
	// plus one long hold-off on request so the codec backs up into its input.
	initial begin
		int mode;
		int seg_len;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			seg_len = $urandom_range(8, 40);
			for (int k = 0; k < seg_len; k++) begin
				@(posedge clk);
				if (hold_req) begin
					hold_req = 1'b0;
					hold_left = 64;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= (k % 4) != 3;
						default: out_ready <= (k % 3) == 0;
					endcase
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic phase_dir[6];
		logic phase_slash[6];
		bit   paused;
		int   wait_cycles;
		phase_dir   = '{DIR_ENCODE, DIR_ENCODE, DIR_DECODE, DIR_ENCODE, DIR_DECODE, DIR_ENCODE};
		phase_slash = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		paused = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encoder from reset: plain letter, both byte extremes, slash passing,
		// tilde, and a percent sign that closes the string
		offer("A", 1'b0);
		offer(8'h00, 1'b0);
		offer(8'hFF, 1'b0);
		offer(CH_SLASH, 1'b0);
		offer("~", 1'b0);
		offer(CH_PERCENT, 1'b1);
		settle();
		// slash now escaped
		write_cfg(REG_ESC_SLASH, 1'b1);
		offer(CH_SLASH, 1'b0);
		offer("q", 1'b1);
		settle();

		write_cfg(REG_DIRECTION, DIR_DECODE);
		// lower-case escape mid-string, then an escape that ends the string
		offer(CH_PERCENT, 1'b0);
		offer("4", 1'b0);
		offer("a", 1'b0);
		offer(CH_PERCENT, 1'b0);
		offer("2", 1'b0);
		offer("F", 1'b1);
		// lone percent at the end of a string: truncated
		offer(CH_PERCENT, 1'b1);
		// non-hex on the last byte in the first digit place: still truncated
		offer(CH_PERCENT, 1'b0);
		offer("G", 1'b1);
		// non-hex mid-string: one error, the tail is dropped
		offer(CH_PERCENT, 1'b0);
		offer("G", 1'b0);
		offer("b", 1'b1);
		// bad second digit on the last byte: error and straight back to idle
		offer(CH_PERCENT, 1'b0);
		offer("4", 1'b0);
		offer("z", 1'b1);
		// a direction write in the middle of an escape throws the escape away
		offer(CH_PERCENT, 1'b0);
		settle();
		write_cfg(REG_DIRECTION, DIR_DECODE);
		offer("A", 1'b1);

		// Random phases over several register settings
		for (int p = 0; p < 6; p++) begin
			settle();
			write_cfg(REG_DIRECTION, phase_dir[p]);
			write_cfg(REG_ESC_SLASH, phase_slash[p]);
			counted = 0;
			// long receiver hold-off while encoding, where backpressure bites hardest
			if (p == 1)
				hold_req = 1'b1;
			while (counted < 37) begin
				if (phase_dir[p] == DIR_ENCODE)
					offer(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				else
					send_decode_string();
				// one pause with the pipe drained in the middle of decoding
				if (p == 2 && counted >= 20 && !paused) begin
					settle();
					paused = 1'b1;
				end
			end
		end

		// Drain, with a bound, then a few cycles for anything stray
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
